// File: hdl/graph_canonical_mask_unit_assert.svh
// Assertion macros for the graph canonical mask unit.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef GRAPH_CANONICAL_MASK_UNIT_ASSERT_SVH
`define GRAPH_CANONICAL_MASK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GCM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("graph canonical mask unit: same-cycle check failed");

// Next-cycle implication.
`define GCM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("graph canonical mask unit: next-cycle check failed");

`endif

// File: hdl/gcm_pkg.sv
// Shared types and constants for the graph canonical mask unit.
// No dependencies.
package gcm_pkg;

	localparam int MASK_W = 15;
	localparam int KIDX_W = 4;
	localparam int CFG_W  = 3;
	localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 3'd6;

	typedef struct packed {
		logic load;
		logic step;
	} gcm_cmd_t;

	typedef struct packed {
		logic last;
	} gcm_sts_t;

endpackage

// File: hdl/gcm_ctrl.sv
// Controller state machine for the graph canonical mask unit.
// Depends on gcm_pkg.
module gcm_ctrl import gcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  gcm_sts_t sts,
	output gcm_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (sts.last) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.step = (state_q == ST_RUN);
	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DONE);

endmodule

// File: hdl/gcm_datapath.sv
// Datapath: adjacency matrix, permutation register with next-permutation
// logic, remap of the edge mask and running minimum. Depends on gcm_pkg.
module gcm_datapath import gcm_pkg::*; #(
	parameter int MAX_VERTICES = 6,
	parameter int VW = $clog2(MAX_VERTICES),
	parameter int NW = $clog2(MAX_VERTICES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gcm_cmd_t          cmd,
	input  logic [MASK_W-1:0] graph_mask,
	input  logic [NW-1:0]     vertex_num,
	output gcm_sts_t          sts,
	output logic [MASK_W-1:0] best
);

	logic                 adj_q  [MAX_VERTICES][MAX_VERTICES];
	logic                 adj_d  [MAX_VERTICES][MAX_VERTICES];
	logic [VW-1:0]        perm_q [MAX_VERTICES];
	logic [VW-1:0]        swp    [MAX_VERTICES];
	logic [VW-1:0]        perm_d [MAX_VERTICES];
	logic [MASK_W-1:0]    best_q;
	logic [MASK_W-1:0]    cur;
	logic [KIDX_W-1:0]    kl;
	logic [KIDX_W-1:0]    kc;
	logic [VW-1:0]        piv;
	logic [VW-1:0]        pm1;
	logic [VW-1:0]        jsel;
	logic                 found;
	int                   src;

	always_comb begin
		kl = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			for (int j = 0; j < MAX_VERTICES; j++) begin
				adj_d[i][j] = 1'b0;
			end
		end
		for (int i = 0; i < MAX_VERTICES; i++) begin
			for (int j = i + 1; j < MAX_VERTICES; j++) begin
				if (NW'(j) < vertex_num) begin
					adj_d[i][j] = graph_mask[kl];
					adj_d[j][i] = graph_mask[kl];
					kl = kl + KIDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		kc  = '0;
		cur = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			for (int j = i + 1; j < MAX_VERTICES; j++) begin
				if (NW'(j) < vertex_num) begin
					cur[kc] = adj_q[perm_q[i]][perm_q[j]];
					kc = kc + KIDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		found = 1'b0;
		piv   = '0;
		jsel  = '0;
		src   = 0;
		for (int i = 1; i < MAX_VERTICES; i++) begin
			if ((NW'(i) < vertex_num) && (perm_q[i-1] < perm_q[i])) begin
				found = 1'b1;
				piv   = VW'(i);
			end
		end
		pm1 = found ? (piv - VW'(1)) : '0;
		for (int j = 0; j < MAX_VERTICES; j++) begin
			if (found && (VW'(j) >= piv) && (NW'(j) < vertex_num)
					&& (perm_q[j] > perm_q[pm1])) begin
				jsel = VW'(j);
			end
		end
		for (int t = 0; t < MAX_VERTICES; t++) begin
			swp[t] = perm_q[t];
		end
		swp[pm1]  = perm_q[jsel];
		swp[jsel] = perm_q[pm1];
		for (int t = 0; t < MAX_VERTICES; t++) begin
			perm_d[t] = swp[t];
			if ((VW'(t) >= piv) && (NW'(t) < vertex_num)) begin
				src       = int'(piv) + int'(vertex_num) - 1 - t;
				perm_d[t] = swp[src[VW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			adj_q <= adj_d;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				perm_q[i] <= VW'(i);
			end
		end else if (cmd.step) begin
			perm_q <= perm_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cmd.load) begin
			best_q <= '1;
		end else if (cmd.step && (cur < best_q)) begin
			best_q <= cur;
		end
	end

	assign sts.last = !found;
	assign best     = best_q;

endmodule

// File: hdl/graph_canonical_mask_unit.sv
// Top level of the graph canonical mask unit: configuration register,
// controller and datapath. Depends on gcm_pkg, gcm_ctrl, gcm_datapath.
//
// Usage:
//  - Input: drive graph_mask and raise start; the item is taken at a rising
//    edge with start high and busy low. busy stays high until the result
//    has been shown.
//  - Output: canonical_mask is valid for exactly one cycle while done is
//    high; the receiver must take it then, it cannot stall the block.
//  - Configuration: cfg_data (vertex count) is written when cfg_valid and
//    cfg_ready are both high; cfg_ready is high while the block is idle
//    and start is low. Counts above MAX_VERTICES act as MAX_VERTICES.
//  - Timing: one permutation is remapped and compared per cycle in the
//    datapath while the controller runs; a new item is accepted only once
//    done has passed and the block is idle again.
//  - Reset: arst_n clears the controller to idle and sets the vertex count
//    to 6; no clearing pass is needed.
`include "graph_canonical_mask_unit_assert.svh"
module graph_canonical_mask_unit import gcm_pkg::*; #(
	parameter int MAX_VERTICES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [MASK_W-1:0] graph_mask,
	output logic              done,
	output logic [MASK_W-1:0] canonical_mask,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [CFG_W-1:0] vertex_count_q;
	logic [NW-1:0]    vertex_num;
	gcm_cmd_t         cmd;
	gcm_sts_t         sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	assign cfg_ready  = !busy && !start;
	assign vertex_num = (int'(vertex_count_q) > MAX_VERTICES) ? NW'(MAX_VERTICES)
		: NW'(vertex_count_q);

	gcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gcm_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.VW           (VW),
		.NW           (NW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.graph_mask (graph_mask),
		.vertex_num (vertex_num),
		.sts        (sts),
		.best       (canonical_mask)
	);

	`GCM_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)
	`GCM_ASSERT_NOW(a_done_busy, done, busy && !cmd.step)
	`GCM_ASSERT_NEXT(a_done_idle, done, !busy && !done)

endmodule
